// ----- src/tsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the timed relay shade controller
// Shade count, timer width, command and mode codes, the step tables of the
// two limit-setting programs and the write port type of the shade timer bank.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // sizing
  localparam int SHADES     = 8;
  localparam int BITS_EACH  = 3;
  localparam int TIMER_BITS = 20;
  localparam int IDX_W      = (SHADES > 1) ? $clog2(SHADES) : 1;
  localparam int RELAY_W    = SHADES * BITS_EACH;
  localparam int CFG_MS_W   = 20;
  localparam int DMS_W      = 20;

  // largest timer value, one bit wider so a 32-bit timer still fits
  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  // relay bits inside a shade group
  localparam logic [BITS_EACH-1:0] UP_BIT   = 3'b001;
  localparam logic [BITS_EACH-1:0] STOP_BIT = 3'b010;
  localparam logic [BITS_EACH-1:0] DOWN_BIT = 3'b100;
  localparam logic [BITS_EACH-1:0] ALL_BITS = 3'b111;

  // command codes
  localparam logic [2:0] CMD_UP        = 3'd0;
  localparam logic [2:0] CMD_STOP      = 3'd1;
  localparam logic [2:0] CMD_DOWN      = 3'd2;
  localparam logic [2:0] CMD_UPLIMIT   = 3'd3;
  localparam logic [2:0] CMD_DOWNLIMIT = 3'd4;
  localparam logic [2:0] CMD_FAVOURITE = 3'd5;
  localparam logic [2:0] CMD_RESETMEM  = 3'd6;
  localparam logic [2:0] CMD_REVERSE   = 3'd7;

  // duration modes
  localparam logic [1:0] MODE_ON    = 2'd0;
  localparam logic [1:0] MODE_OFF   = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;
  localparam logic [1:0] MODE_MS    = 2'd3;

  // input kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SHADES = 2'd0;
  localparam logic [1:0] REG_MAX_ON = 2'd1;
  localparam logic [1:0] REG_PULSE  = 2'd2;

  // fixed durations in milliseconds
  localparam logic [31:0] FIXED_STOP_MS  = 32'd7000;
  localparam logic [31:0] FIXED_RESET_MS = 32'd15000;

  // timer bank operations
  typedef enum logic [1:0] {
    BK_NOP,
    BK_INC,
    BK_LOAD
  } bank_op_e;

  // timer bank write request
  typedef struct packed {
    bank_op_e               op;
    logic [IDX_W-1:0]       idx;
    logic [TIMER_BITS-1:0]  timeout;
  } bank_wr_t;

  // timer bank status of the addressed shade
  typedef struct packed {
    logic active;
    logic reached;
  } bank_stat_t;

  // one step of a limit-setting program
  typedef struct packed {
    logic [BITS_EACH-1:0]  mask;
    logic                  on;
    logic [TIMER_BITS-1:0] ms;
  } step_t;

  // clamp a duration to the timer range
  function automatic logic [TIMER_BITS-1:0] timer_sat(input logic [31:0] v);
    logic [32:0] w;
    begin
      w = {1'b0, v};
      if (w > TIMER_MAX) begin
        timer_sat = TIMER_MAX[TIMER_BITS-1:0];
      end else begin
        timer_sat = w[TIMER_BITS-1:0];
      end
    end
  endfunction

  // program length: up-limit has two steps, down-limit four
  function automatic logic [2:0] prog_len(input logic sel);
    begin
      prog_len = sel ? 3'd4 : 3'd2;
    end
  endfunction

  // step table of both programs
  function automatic step_t prog_step(input logic sel, input logic [1:0] idx);
    step_t s;
    begin
      s.mask = STOP_BIT;
      s.on   = 1'b1;
      s.ms   = timer_sat(32'd500);
      if (!sel) begin
        case (idx[0])
          1'b0: begin
            s.mask = DOWN_BIT | STOP_BIT;
            s.ms   = timer_sat(32'd1500);
          end
          default: begin
            s.mask = STOP_BIT;
            s.ms   = timer_sat(32'd500);
          end
        endcase
      end else begin
        case (idx)
          2'd0: begin
            s.mask = UP_BIT | STOP_BIT;
            s.ms   = timer_sat(32'd1500);
          end
          2'd1: begin
            s.mask = STOP_BIT;
            s.ms   = timer_sat(32'd500);
          end
          2'd2: begin
            s.mask = STOP_BIT;
            s.on   = 1'b0;
            s.ms   = timer_sat(32'd2000);
          end
          default: begin
            s.mask = STOP_BIT;
            s.ms   = timer_sat(32'd7000);
          end
        endcase
      end
      prog_step = s;
    end
  endfunction

endpackage

// ----- src/tsc_shade_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_shade_bank: per-shade elapsed and timeout counters
// Holds the two timer arrays and the one shared compare and increment unit
// that the sequencer points at a shade each cycle.
// ----------------------------------------------------------------------------
module tsc_shade_bank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tsc_pkg::IDX_W-1:0] rd_idx_i,
  input  tsc_pkg::bank_wr_t         wr_i,
  output tsc_pkg::bank_stat_t       stat_o,
  output logic [tsc_pkg::SHADES-1:0] busy_o
);

  logic [tsc_pkg::TIMER_BITS-1:0] elapsed_q [tsc_pkg::SHADES];
  logic [tsc_pkg::TIMER_BITS-1:0] timeout_q [tsc_pkg::SHADES];
  logic [tsc_pkg::TIMER_BITS-1:0] rd_elapsed;
  logic [tsc_pkg::TIMER_BITS-1:0] rd_timeout;
  logic [tsc_pkg::TIMER_BITS-1:0] elapsed_inc;

  // shared compare and increment on the addressed shade
  always_comb begin
    rd_elapsed     = elapsed_q[rd_idx_i];
    rd_timeout     = timeout_q[rd_idx_i];
    stat_o.active  = (rd_timeout != '0);
    stat_o.reached = (rd_elapsed >= rd_timeout);
    elapsed_inc    = rd_elapsed + tsc_pkg::TIMER_BITS'(1);
  end

  // busy flags of all shades
  always_comb begin
    for (int k = 0; k < tsc_pkg::SHADES; k++) begin
      busy_o[k] = (timeout_q[k] != '0);
    end
  end

  // timer update, one shade per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tsc_pkg::SHADES; k++) begin
        elapsed_q[k] <= '0;
        timeout_q[k] <= '0;
      end
    end else begin
      case (wr_i.op)
        tsc_pkg::BK_INC: begin
          elapsed_q[rd_idx_i] <= elapsed_inc;
        end
        tsc_pkg::BK_LOAD: begin
          elapsed_q[wr_i.idx] <= '0;
          timeout_q[wr_i.idx] <= wr_i.timeout;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/timed_relay_shade_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_relay_shade_controller_unit: timed relay control of window shades
// Commands drive the up, stop and down relays of one shade for a duration;
// millisecond ticks age the timers and advance the limit-setting programs.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: index, command, mode, ms
//                                        tuser: kind
//  m_axis    out  tvalid/tready          tdata: relays, busy, accepted, seq
//  apb       in   psel/penable/pready    three 32-bit registers at 0, 4, 8
//
// A command is latched on acceptance, executed in ST_CMD and its result loaded
// in ST_DONE; a tick walks the shades one per cycle through the single timer
// compare and increment unit, then loads its result in ST_DONE.
// Reset clears all relays, timers and the program; registers reload defaults.
// s_axis_tready is low while an item is in work; a stalled result holds in
// the output register while the next item is already taken.
// ----------------------------------------------------------------------------
module timed_relay_shade_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [2:0] shade_index, [5:3] command,
                                      // [7:6] duration_mode, [27:8] duration_ms
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [23:0] control_bits, [31:24] busy_mask,
                                      // [32] accepted, [33] sequence_active
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [tsc_pkg::IDX_W-1:0] LAST_IDX = tsc_pkg::IDX_W'(tsc_pkg::SHADES - 1);

  // configuration registers
  logic [3:0]                   shades_q;
  logic [tsc_pkg::CFG_MS_W-1:0] max_on_q;
  logic [tsc_pkg::CFG_MS_W-1:0] pulse_q;

  // sequencer and latched command
  logic [1:0]                state_q, state_d;
  logic [tsc_pkg::IDX_W-1:0] scan_q, scan_d;
  logic                      halt_q, halt_d;
  logic [2:0]                cmd_idx_q, cmd_idx_d;
  logic [2:0]                cmd_op_q, cmd_op_d;
  logic [1:0]                cmd_mode_q, cmd_mode_d;
  logic [tsc_pkg::DMS_W-1:0] cmd_dms_q, cmd_dms_d;
  logic                      acc_q, acc_d;

  // relay word and program state
  logic [tsc_pkg::RELAY_W-1:0] relay_q, relay_d;
  logic                        prog_running_q, prog_running_d;
  logic [tsc_pkg::IDX_W-1:0]   prog_shade_q, prog_shade_d;
  logic                        prog_select_q, prog_select_d;
  logic [1:0]                  prog_step_q, prog_step_d;

  // result register
  logic        m_tvalid_q, m_tvalid_d;
  logic [39:0] m_tdata_q, m_tdata_d;

  // timer bank connection
  tsc_pkg::bank_wr_t          bank_wr;
  tsc_pkg::bank_stat_t        bank_stat;
  logic [tsc_pkg::SHADES-1:0] busy;

  // relay group update
  logic                         grp_we;
  logic [tsc_pkg::IDX_W-1:0]    grp_idx;
  logic [tsc_pkg::BITS_EACH-1:0] grp_val;

  logic cfg_we;

  tsc_shade_bank u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (scan_q),
    .wr_i     (bank_wr),
    .stat_o   (bank_stat),
    .busy_o   (busy)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      tsc_pkg::REG_SHADES: prdata = {28'd0, shades_q};
      tsc_pkg::REG_MAX_ON: prdata = {12'd0, max_on_q};
      tsc_pkg::REG_PULSE:  prdata = {12'd0, pulse_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shades_q <= 4'd8;
      max_on_q <= 20'd60000;
      pulse_q  <= 20'd500;
    end else if (cfg_we) begin
      case (paddr[3:2])
        tsc_pkg::REG_SHADES: shades_q <= pwdata[3:0];
        tsc_pkg::REG_MAX_ON: max_on_q <= pwdata[19:0];
        tsc_pkg::REG_PULSE:  pulse_q  <= pwdata[19:0];
        default: begin
        end
      endcase
    end
  end

  // handshake outputs
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // sequencer
  always_comb begin
    tsc_pkg::step_t            st;
    logic [tsc_pkg::TIMER_BITS-1:0] ms;
    logic                      on;
    logic [tsc_pkg::BITS_EACH-1:0] mask;
    logic [2:0]                step_nx;
    logic                      in_range;
    logic                      sel_new;

    state_d        = state_q;
    scan_d         = scan_q;
    halt_d         = halt_q;
    cmd_idx_d      = cmd_idx_q;
    cmd_op_d       = cmd_op_q;
    cmd_mode_d     = cmd_mode_q;
    cmd_dms_d      = cmd_dms_q;
    acc_d          = acc_q;
    relay_d        = relay_q;
    prog_running_d = prog_running_q;
    prog_shade_d   = prog_shade_q;
    prog_select_d  = prog_select_q;
    prog_step_d    = prog_step_q;
    m_tvalid_d     = m_tvalid_q;
    m_tdata_d      = m_tdata_q;
    bank_wr.op      = tsc_pkg::BK_NOP;
    bank_wr.idx     = scan_q;
    bank_wr.timeout = '0;
    grp_we  = 1'b0;
    grp_idx = scan_q;
    grp_val = '0;
    st       = tsc_pkg::prog_step(1'b0, 2'd0);
    ms       = '0;
    on       = 1'b1;
    mask     = tsc_pkg::STOP_BIT;
    step_nx  = {1'b0, prog_step_q} + 3'd1;
    in_range = 1'b0;
    sel_new  = 1'b0;

    // result leaves the output register
    if (m_tvalid_q && m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_idx_d  = s_axis_tdata[2:0];
          cmd_op_d   = s_axis_tdata[5:3];
          cmd_mode_d = s_axis_tdata[7:6];
          cmd_dms_d  = s_axis_tdata[27:8];
          acc_d      = 1'b1;
          scan_d     = '0;
          halt_d     = 1'b0;
          state_d    = (s_axis_tuser == tsc_pkg::KIND_CMD) ? ST_CMD : ST_SCAN;
        end
      end

      ST_CMD: begin
        in_range = ({1'b0, cmd_idx_q} < shades_q) && (32'(cmd_idx_q) < tsc_pkg::SHADES);
        acc_d    = in_range;
        // duration from the mode
        case (cmd_mode_q)
          tsc_pkg::MODE_ON:    ms = tsc_pkg::timer_sat(32'(max_on_q));
          tsc_pkg::MODE_OFF: begin
            on = 1'b0;
            ms = '0;
          end
          tsc_pkg::MODE_PULSE: ms = tsc_pkg::timer_sat(32'(pulse_q));
          default:             ms = tsc_pkg::timer_sat(32'(cmd_dms_q));
        endcase
        // relay mask and fixed durations
        case (cmd_op_q)
          tsc_pkg::CMD_UP:   mask = tsc_pkg::UP_BIT;
          tsc_pkg::CMD_STOP: mask = tsc_pkg::STOP_BIT;
          tsc_pkg::CMD_DOWN: mask = tsc_pkg::DOWN_BIT;
          tsc_pkg::CMD_RESETMEM: begin
            mask = tsc_pkg::ALL_BITS;
            ms   = tsc_pkg::timer_sat(tsc_pkg::FIXED_RESET_MS);
          end
          tsc_pkg::CMD_FAVOURITE, tsc_pkg::CMD_REVERSE: begin
            mask = tsc_pkg::STOP_BIT;
            ms   = tsc_pkg::timer_sat(tsc_pkg::FIXED_STOP_MS);
          end
          default: mask = tsc_pkg::STOP_BIT;
        endcase
        if (in_range) begin
          if (cmd_op_q == tsc_pkg::CMD_UPLIMIT || cmd_op_q == tsc_pkg::CMD_DOWNLIMIT) begin
            // start a program unless one already runs
            if (!prog_running_q) begin
              sel_new         = (cmd_op_q == tsc_pkg::CMD_DOWNLIMIT);
              st              = tsc_pkg::prog_step(sel_new, 2'd0);
              prog_running_d  = 1'b1;
              prog_shade_d    = tsc_pkg::IDX_W'(cmd_idx_q);
              prog_select_d   = sel_new;
              prog_step_d     = 2'd0;
              bank_wr.op      = tsc_pkg::BK_LOAD;
              bank_wr.idx     = tsc_pkg::IDX_W'(cmd_idx_q);
              bank_wr.timeout = st.ms;
              grp_we          = 1'b1;
              grp_idx         = tsc_pkg::IDX_W'(cmd_idx_q);
              grp_val         = st.on ? st.mask : '0;
            end
          end else begin
            bank_wr.op      = tsc_pkg::BK_LOAD;
            bank_wr.idx     = tsc_pkg::IDX_W'(cmd_idx_q);
            bank_wr.timeout = ms;
            grp_we          = 1'b1;
            grp_idx         = tsc_pkg::IDX_W'(cmd_idx_q);
            grp_val         = on ? mask : '0;
          end
        end
        state_d = ST_DONE;
      end

      ST_SCAN: begin
        if (bank_stat.active) begin
          if (!bank_stat.reached) begin
            bank_wr.op = tsc_pkg::BK_INC;
          end else if (!halt_q) begin
            // expired shade: clear it
            bank_wr.op      = tsc_pkg::BK_LOAD;
            bank_wr.timeout = '0;
            grp_we          = 1'b1;
            grp_val         = '0;
            // program shade expired: advance the program, later shades wait
            if (prog_running_q && scan_q == prog_shade_q) begin
              halt_d = 1'b1;
              if (step_nx >= tsc_pkg::prog_len(prog_select_q)) begin
                prog_running_d = 1'b0;
                prog_step_d    = 2'd0;
              end else begin
                st              = tsc_pkg::prog_step(prog_select_q, step_nx[1:0]);
                prog_step_d     = step_nx[1:0];
                bank_wr.timeout = st.ms;
                grp_val         = st.on ? st.mask : '0;
              end
            end
          end
        end
        if (scan_q == LAST_IDX) begin
          state_d = ST_DONE;
        end else begin
          scan_d = scan_q + tsc_pkg::IDX_W'(1);
        end
      end

      ST_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {6'd0, prog_running_q, acc_q, 8'(busy), 24'(relay_q)};
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // relay group write
    if (grp_we) begin
      relay_d[grp_idx*tsc_pkg::BITS_EACH +: tsc_pkg::BITS_EACH] = grp_val;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      scan_q         <= '0;
      halt_q         <= 1'b0;
      acc_q          <= 1'b1;
      relay_q        <= '0;
      prog_running_q <= 1'b0;
      prog_shade_q   <= '0;
      prog_select_q  <= 1'b0;
      prog_step_q    <= 2'd0;
      m_tvalid_q     <= 1'b0;
    end else begin
      state_q        <= state_d;
      scan_q         <= scan_d;
      halt_q         <= halt_d;
      acc_q          <= acc_d;
      relay_q        <= relay_d;
      prog_running_q <= prog_running_d;
      prog_shade_q   <= prog_shade_d;
      prog_select_q  <= prog_select_d;
      prog_step_q    <= prog_step_d;
      m_tvalid_q     <= m_tvalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_idx_q  <= cmd_idx_d;
    cmd_op_q   <= cmd_op_d;
    cmd_mode_q <= cmd_mode_d;
    cmd_dms_q  <= cmd_dms_d;
    m_tdata_q  <= m_tdata_d;
  end

  // program step stays zero while no program runs
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !prog_running_q |-> prog_step_q == 2'd0)
    else $error("program step nonzero while idle");

  // up-limit program never goes past its second step
  a_step_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_running_q && !prog_select_q |-> !prog_step_q[1])
    else $error("up-limit program step out of range");

  // an accepted transaction blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // tick scan visits every shade before finishing
  a_scan_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && scan_q != LAST_IDX |=> state_q == ST_SCAN)
    else $error("tick scan ended early");

endmodule
